>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is high.
`define SHM_ASSERT(label, clk_s, rst_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// Clocked check that also holds during reset.
`define SHM_ASSERT_ALWAYS(label, clk_s, prop, msg) \
  label: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

>>> hw/rtl/shm_pkg.sv
// Package: types and codes of the sensor health monitor.
`timescale 1ns / 1ps
`default_nettype none
package shm_pkg;

  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  typedef enum logic [2:0] {
    OP_RESTART = 3'd0,
    OP_SUCCESS = 3'd1,
    OP_FAILURE = 3'd2,
    OP_OFFLINE = 3'd3,
    OP_TICK    = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    MODE_STARTING = 3'd0,
    MODE_OK       = 3'd1,
    MODE_DEGRADED = 3'd2,
    MODE_STALE    = 3'd3,
    MODE_OFFLINE  = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    REG_STALE_TIMEOUT  = 2'd0,
    REG_RETRY_INTERVAL = 2'd1,
    REG_FAILURE_LIMIT  = 2'd2
  } reg_idx_t;

  localparam logic [31:0] STALE_TIMEOUT_RST  = 32'd1000;
  localparam logic [31:0] RETRY_INTERVAL_RST = 32'd1000;
  localparam logic [15:0] FAILURE_LIMIT_RST  = 16'd3;

  typedef struct packed {
    logic [31:0] stale_timeout;
    logic [31:0] retry_interval;
    logic [15:0] failure_limit;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  health_state;
    logic        retry_due;
    logic [15:0] run_failures;
    logic [31:0] all_failures;
    logic        ever_succeeded;
  } res_t;

  typedef struct packed {
    mode_t mode;
    logic  seen_success;
  } core_stat_t;

endpackage
`default_nettype wire

>>> hw/rtl/shm_if.sv
// Interfaces: event channel and result channel.
`timescale 1ns / 1ps
`default_nettype none
interface shm_evt_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [31:0] now_time;

  modport source (output valid, output op, output now_time, input ready);
  modport sink (input valid, input op, input now_time, output ready);
endinterface

interface shm_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  health_state;
  logic        retry_due;
  logic [15:0] run_failures;
  logic [31:0] all_failures;
  logic        ever_succeeded;

  modport source (output valid, output health_state, output retry_due,
                  output run_failures, output all_failures,
                  output ever_succeeded, input ready);
  modport sink (input valid, input health_state, input retry_due,
                input run_failures, input all_failures,
                input ever_succeeded, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/shm_cfg.sv
// Configuration registers behind an APB-style port.
`timescale 1ns / 1ps
`default_nettype none
module shm_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [shm_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [shm_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [shm_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                 pready,
  output shm_pkg::cfg_t                        cfg
);

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stale_timeout  <= shm_pkg::STALE_TIMEOUT_RST;
      cfg.retry_interval <= shm_pkg::RETRY_INTERVAL_RST;
      cfg.failure_limit  <= shm_pkg::FAILURE_LIMIT_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        shm_pkg::REG_STALE_TIMEOUT:  cfg.stale_timeout  <= pwdata;
        shm_pkg::REG_RETRY_INTERVAL: cfg.retry_interval <= pwdata;
        shm_pkg::REG_FAILURE_LIMIT:  cfg.failure_limit  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      shm_pkg::REG_STALE_TIMEOUT:  prdata = cfg.stale_timeout;
      shm_pkg::REG_RETRY_INTERVAL: prdata = cfg.retry_interval;
      shm_pkg::REG_FAILURE_LIMIT:  prdata = {16'd0, cfg.failure_limit};
      default:                     prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> hw/rtl/shm_core.sv
// Tracker state and per-event update logic.
`timescale 1ns / 1ps
`default_nettype none
module shm_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire logic [2:0]      op,
  input  wire logic [31:0]     now_time,
  input  wire shm_pkg::cfg_t   cfg,
  output shm_pkg::res_t        result,
  output shm_pkg::core_stat_t  stat
);

  shm_pkg::mode_t mode, mode_next;
  logic [31:0] last_good_time, last_good_time_next;
  logic [31:0] retry_time, retry_time_next;
  logic [15:0] fail_run, fail_run_next;
  logic [31:0] fail_total, fail_total_next;
  logic        seen_success, seen_success_next;

  logic [15:0] limit;
  logic [31:0] stale_deadline;
  logic [31:0] stale_diff;
  logic [31:0] retry_diff;
  logic        stale_reached;

  assign limit          = (cfg.failure_limit == 16'd0) ? 16'd1 : cfg.failure_limit;
  assign stale_deadline = last_good_time + cfg.stale_timeout;
  assign stale_diff     = now_time - stale_deadline;
  // wrap-safe compare: reached when the signed difference is non-negative
  assign stale_reached  = !stale_diff[31];

  always_comb begin
    mode_next           = mode;
    last_good_time_next = last_good_time;
    retry_time_next     = retry_time;
    fail_run_next       = fail_run;
    fail_total_next     = fail_total;
    seen_success_next   = seen_success;
    case (op)
      shm_pkg::OP_RESTART: begin
        mode_next           = shm_pkg::MODE_STARTING;
        last_good_time_next = now_time;
        retry_time_next     = now_time + cfg.stale_timeout;
        fail_run_next       = '0;
        fail_total_next     = '0;
        seen_success_next   = 1'b0;
      end
      shm_pkg::OP_SUCCESS: begin
        mode_next           = shm_pkg::MODE_OK;
        last_good_time_next = now_time;
        fail_run_next       = '0;
        seen_success_next   = 1'b1;
      end
      shm_pkg::OP_FAILURE: begin
        fail_total_next = fail_total + 32'd1;
        fail_run_next   = (fail_run == 16'hFFFF) ? fail_run : fail_run + 16'd1;
        if (fail_run_next >= limit) begin
          mode_next       = shm_pkg::MODE_OFFLINE;
          retry_time_next = now_time + cfg.retry_interval;
        end else begin
          mode_next = shm_pkg::MODE_DEGRADED;
        end
      end
      shm_pkg::OP_OFFLINE: begin
        mode_next       = shm_pkg::MODE_OFFLINE;
        retry_time_next = now_time + cfg.retry_interval;
      end
      shm_pkg::OP_TICK: begin
        if (seen_success && stale_reached &&
            (mode == shm_pkg::MODE_OK || mode == shm_pkg::MODE_DEGRADED)) begin
          mode_next       = shm_pkg::MODE_STALE;
          retry_time_next = now_time;
        end
      end
      default: ;
    endcase
  end

  assign retry_diff = now_time - retry_time_next;

  always_comb begin
    result.health_state   = mode_next;
    result.retry_due      = !retry_diff[31] &&
                            (mode_next == shm_pkg::MODE_STARTING ||
                             mode_next == shm_pkg::MODE_OFFLINE ||
                             mode_next == shm_pkg::MODE_STALE);
    result.run_failures   = fail_run_next;
    result.all_failures   = fail_total_next;
    result.ever_succeeded = seen_success_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= shm_pkg::MODE_STARTING;
      last_good_time <= '0;
      retry_time     <= '0;
      fail_run       <= '0;
      fail_total     <= '0;
      seen_success   <= 1'b0;
    end else if (accept) begin
      mode           <= mode_next;
      last_good_time <= last_good_time_next;
      retry_time     <= retry_time_next;
      fail_run       <= fail_run_next;
      fail_total     <= fail_total_next;
      seen_success   <= seen_success_next;
    end
  end

  assign stat.mode         = mode;
  assign stat.seen_success = seen_success;

endmodule
`default_nettype wire

>>> hw/rtl/shm_outbuf.sv
// Two-entry result queue: output register plus skid slot.
`timescale 1ns / 1ps
`default_nettype none
module shm_outbuf (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire shm_pkg::res_t  push_data,
  output logic                push_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  output shm_pkg::res_t       out_data
);

  logic [1:0]    count;
  shm_pkg::res_t slot0;
  shm_pkg::res_t slot1;
  logic          pop;

  assign push_ready = (count != 2'd2);
  assign out_valid  = (count != 2'd0);
  assign out_data   = slot0;
  assign pop        = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // slot0 is the head; slot1 only holds data while the head is stalled
  always_ff @(posedge clk) begin
    if (pop) begin
      slot0 <= (count == 2'd2) ? slot1 : push_data;
    end else if (push && count == 2'd0) begin
      slot0 <= push_data;
    end
    if (push && !pop && count == 2'd1) begin
      slot1 <= push_data;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/sensor_health_monitor_unit.sv
// Sensor health monitor: top level.
//
// Usage: events (op, now_time) enter on the evt channel, one result per
// event leaves on the res channel in event order. The tracker state is
// updated in the cycle the event transaction completes and the result is
// visible on res the next cycle if the queue was empty. Throughput is one
// event per cycle while the queue is not full; the update is a few adds
// and compares between the state registers and the result queue.
// Results sit in a two-entry queue, so evt stays ready while one result
// waits on a stalled receiver; evt.ready drops only when both entries are
// occupied and comes back the cycle after res takes a result.
// Reset (rst, synchronous) puts the tracker in starting with all counters
// and times cleared, empties the queue, and loads the default register
// values (stale_timeout 1000, retry_interval 1000, failure_limit 3).
// Registers sit at byte addresses 0, 4 and 8 of the APB port and should be
// written only while no event is in flight.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sensor_health_monitor_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  shm_evt_if.sink                              evt,
  shm_res_if.source                            res,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [shm_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [shm_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [shm_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                 pready
);

  shm_pkg::cfg_t       cfg;
  shm_pkg::res_t       core_res;
  shm_pkg::res_t       out_data;
  shm_pkg::core_stat_t stat;
  logic                evt_accept;
  logic                buf_ready;

  assign evt.ready  = buf_ready;
  assign evt_accept = evt.valid && buf_ready;

  shm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  shm_core u_core (
    .clk      (clk),
    .rst      (rst),
    .accept   (evt_accept),
    .op       (evt.op),
    .now_time (evt.now_time),
    .cfg      (cfg),
    .result   (core_res),
    .stat     (stat)
  );

  shm_outbuf u_outbuf (
    .clk        (clk),
    .rst        (rst),
    .push       (evt_accept),
    .push_data  (core_res),
    .push_ready (buf_ready),
    .out_valid  (res.valid),
    .out_ready  (res.ready),
    .out_data   (out_data)
  );

  assign res.health_state   = out_data.health_state;
  assign res.retry_due      = out_data.retry_due;
  assign res.run_failures   = out_data.run_failures;
  assign res.all_failures   = out_data.all_failures;
  assign res.ever_succeeded = out_data.ever_succeeded;

  `SHM_ASSERT(a_evt_gives_res, clk, rst, evt_accept |=> res.valid, "event produced no result")
  `SHM_ASSERT(a_stall_only_full, clk, rst, !evt.ready |-> res.valid, "input stalled with empty queue")
  `SHM_ASSERT(a_ok_needs_success, clk, rst, (stat.mode == shm_pkg::MODE_OK) |-> stat.seen_success, "ok without success")

endmodule
`default_nettype wire
